>>> hdl/trcp_pkg.sv
// Shared constants for the two-ray closest point pipeline.
// No dependencies; imported by the multiplier and the top level.
`default_nettype none

package trcp_pkg;

    localparam int MUL_DIGIT = 32;

    typedef logic [MUL_DIGIT-1:0] digit_t;

endpackage

`default_nettype wire

>>> hdl/trcp_delay.sv
// Enabled shift line that aligns side data with the multiplier and divider stages.
// No dependencies.
`default_nettype none

module trcp_delay
#(
    parameter int W = 1,
    parameter int N = 1
)(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

`default_nettype wire

>>> hdl/trcp_mul.sv
// Pipelined signed multiplier: one digit-by-digit partial product per stage.
// Depends on trcp_pkg and trcp_delay.
`default_nettype none

module trcp_mul
    import trcp_pkg::*;
#(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int LAT = 3
)(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA  = (AW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NB  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NP  = NA * NB;
    localparam int PW  = AW + BW;
    localparam int PAD = LAT - NP - 2;

    logic [AW-1:0]        am_reg  [NP];
    logic [BW-1:0]        bm_reg  [NP];
    logic                 sg_reg  [NP+1];
    logic [PW-1:0]        acc_reg [NP];
    logic [PW-1:0]        term    [NP];
    logic signed [PW-1:0] p_reg;

    for (genvar k = 0; k < NP; k++)
    begin : g_term
        localparam int IA = k / NB;
        localparam int IB = k % NB;
        logic [NA*MUL_DIGIT-1:0] ax;
        logic [NB*MUL_DIGIT-1:0] bx;
        digit_t                  da;
        digit_t                  db;
        logic [2*MUL_DIGIT-1:0]  pp;
        assign ax = (NA*MUL_DIGIT)'(am_reg[k]);
        assign bx = (NB*MUL_DIGIT)'(bm_reg[k]);
        assign da = ax[IA*MUL_DIGIT +: MUL_DIGIT];
        assign db = bx[IB*MUL_DIGIT +: MUL_DIGIT];
        assign pp = da * db;
        assign term[k] = PW'(pp) << ((IA + IB) * MUL_DIGIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg[0] <= a[AW-1] ? AW'(-a) : AW'(a);
            bm_reg[0] <= b[BW-1] ? BW'(-b) : BW'(b);
            sg_reg[0] <= a[AW-1] ^ b[BW-1];
            for (int k = 1; k < NP; k++)
            begin
                am_reg[k] <= am_reg[k-1];
                bm_reg[k] <= bm_reg[k-1];
            end
            acc_reg[0] <= term[0];
            for (int k = 1; k < NP; k++)
            begin
                acc_reg[k] <= acc_reg[k-1] + term[k];
            end
            for (int k = 0; k < NP; k++)
            begin
                sg_reg[k+1] <= sg_reg[k];
            end
            p_reg <= sg_reg[NP] ? PW'(-acc_reg[NP-1]) : acc_reg[NP-1];
        end
    end

    if (PAD > 0)
    begin : g_pad
        logic [PW-1:0] p_pad;
        trcp_delay #(.W(PW), .N(PAD)) u_pad
        (
            .clk  (clk),
            .en   (en),
            .din  (p_reg),
            .dout (p_pad)
        );
        assign p = p_pad;
    end
    else
    begin : g_nopad
        assign p = p_reg;
    end

endmodule

`default_nettype wire

>>> hdl/trcp_mid.sv
// Midpoint rounding divider: round(num / 2s) ties away from zero, saturated.
// Restoring division, one quotient bit per stage.
`default_nettype none

module trcp_mid
#(
    parameter int POS_W = 42,
    parameter int NUMW  = 178,
    parameter int SW    = 132
)(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [NUMW-1:0] num,
    input  logic [SW-1:0]          s,
    output logic [POS_W-1:0]       mid
);

    localparam int LW   = NUMW + 1;
    localparam int DENW = SW + 1;
    localparam int RW   = (LW > DENW + POS_W ? LW : DENW + POS_W) + 1;
    localparam logic [POS_W-1:0] TOP = {1'b1, {(POS_W-1){1'b0}}};

    logic [RW-1:0]    r_reg   [POS_W];
    logic [DENW-1:0]  den_reg [POS_W];
    logic [POS_W-1:0] q_reg   [POS_W+1];
    logic             neg_reg [POS_W+1];
    logic [RW-1:0]    trial   [POS_W];
    logic [NUMW-1:0]  mag;
    logic [POS_W-1:0] q_fin;

    assign mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

    always_comb
    begin
        for (int k = 0; k < POS_W; k++)
        begin
            trial[k] = r_reg[k] - (RW'(den_reg[k]) << (POS_W - 1 - k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= RW'(mag) + RW'(s);
            den_reg[0] <= {s, 1'b0};
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUMW-1];
            for (int k = 0; k < POS_W; k++)
            begin
                neg_reg[k+1] <= neg_reg[k];
                if (!trial[k][RW-1])
                begin
                    q_reg[k+1] <= q_reg[k] | (POS_W'(1) << (POS_W - 1 - k));
                end
                else
                begin
                    q_reg[k+1] <= q_reg[k];
                end
            end
            for (int k = 0; k < POS_W - 1; k++)
            begin
                den_reg[k+1] <= den_reg[k];
                r_reg[k+1]   <= trial[k][RW-1] ? r_reg[k] : trial[k];
            end
        end
    end

    always_comb
    begin
        q_fin = q_reg[POS_W];
        if (neg_reg[POS_W])
        begin
            if (q_fin > TOP)
            begin
                q_fin = TOP;
            end
            mid = -q_fin;
        end
        else
        begin
            if (q_fin > TOP - 1'b1)
            begin
                q_fin = TOP - 1'b1;
            end
            mid = q_fin;
        end
    end

endmodule

`default_nettype wire

>>> hdl/trcp_half.sv
// Half-distance search: largest h with (2h-1)^2 * s <= n^2, one bit per stage.
// Residue and (2h-1)*s are updated by shifts only.
`default_nettype none

module trcp_half
#(
    parameter int POS_W = 42,
    parameter int N2W   = 220,
    parameter int SW    = 132
)(
    input  logic             clk,
    input  logic             en,
    input  logic [N2W-1:0]   n2,
    input  logic [SW-1:0]    s,
    output logic [POS_W-1:0] h
);

    localparam int EW = (N2W > SW + 2*POS_W + 3 ? N2W : SW + 2*POS_W + 3) + 2;
    localparam int GW = SW + POS_W + 3;

    logic signed [EW-1:0] e_reg [POS_W];
    logic signed [GW-1:0] g_reg [POS_W];
    logic [SW-1:0]        s_reg [POS_W];
    logic [POS_W-1:0]     h_reg [POS_W+1];
    logic [EW-1:0]        t     [POS_W];

    always_comb
    begin
        for (int k = 0; k < POS_W; k++)
        begin
            t[k] = e_reg[k] - (EW'(g_reg[k]) << (POS_W + 1 - k))
                 - (EW'(s_reg[k]) << (2*(POS_W - 1 - k) + 2));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= EW'(n2) - EW'(s);
            g_reg[0] <= -GW'(s);
            s_reg[0] <= s;
            h_reg[0] <= '0;
            for (int k = 0; k < POS_W; k++)
            begin
                if (!t[k][EW-1])
                begin
                    h_reg[k+1] <= h_reg[k] | (POS_W'(1) << (POS_W - 1 - k));
                end
                else
                begin
                    h_reg[k+1] <= h_reg[k];
                end
            end
            for (int k = 0; k < POS_W - 1; k++)
            begin
                s_reg[k+1] <= s_reg[k];
                if (!t[k][EW-1])
                begin
                    e_reg[k+1] <= t[k];
                    g_reg[k+1] <= g_reg[k] + (GW'(s_reg[k]) << (POS_W - k));
                end
                else
                begin
                    e_reg[k+1] <= e_reg[k];
                    g_reg[k+1] <= g_reg[k];
                end
            end
        end
    end

    assign h = h_reg[POS_W];

endmodule

`default_nettype wire

>>> hdl/two_ray_closest_point.sv
// Top level: closest points between two skew rays, exact fixed point pipeline.
// Depends on trcp_pkg, trcp_delay, trcp_mul, trcp_mid and trcp_half.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------------------
//  pair    | pair_valid | pair_stall | p1_*, u1_*, p2_*, u2_*
//  result  | res_valid  | res_stall  | mid_x, mid_y, mid_z, half_distance, parallel
//
// One ray pair per clock while the result is not stalled. The pipeline depth is
// set by the 32x32 partial-product multiplier chains and the one-bit-per-stage
// divide and square-root recurrences.
// Reset clears the valid bits only. A stalled result freezes the whole pipeline.
`default_nettype none

module two_ray_closest_point
    import trcp_pkg::*;
#(
    parameter int POS_WIDTH = 42,
    parameter int DIR_FRAC  = 30
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pair_valid,
    output logic                        pair_stall,
    input  logic signed [POS_WIDTH-1:0] p1_x,
    input  logic signed [POS_WIDTH-1:0] p1_y,
    input  logic signed [POS_WIDTH-1:0] p1_z,
    input  logic signed [DIR_FRAC+1:0]  u1_x,
    input  logic signed [DIR_FRAC+1:0]  u1_y,
    input  logic signed [DIR_FRAC+1:0]  u1_z,
    input  logic signed [POS_WIDTH-1:0] p2_x,
    input  logic signed [POS_WIDTH-1:0] p2_y,
    input  logic signed [POS_WIDTH-1:0] p2_z,
    input  logic signed [DIR_FRAC+1:0]  u2_x,
    input  logic signed [DIR_FRAC+1:0]  u2_y,
    input  logic signed [DIR_FRAC+1:0]  u2_z,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic signed [POS_WIDTH-1:0] mid_x,
    output logic signed [POS_WIDTH-1:0] mid_y,
    output logic signed [POS_WIDTH-1:0] mid_z,
    output logic [POS_WIDTH-1:0]        half_distance,
    output logic                        parallel
);

    localparam int P   = POS_WIDTH;
    localparam int D   = DIR_FRAC + 2;
    localparam int G   = MUL_DIGIT;
    localparam int MW  = 2*D + 1;
    localparam int DW  = P + 1;
    localparam int SW  = 4*D + 4;
    localparam int CW  = DW + MW + 1;
    localparam int AW1 = CW + D + 2;
    localparam int DMW = DW + MW + 2;
    localparam int N2W = 2*DMW;
    localparam int SPW = SW + 1 + DW;
    localparam int NMW = (SPW > AW1 + D ? SPW : AW1 + D) + 2;

    localparam int ND  = (D + G - 1) / G;
    localparam int NM  = (MW + G - 1) / G;
    localparam int NDW = (DW + G - 1) / G;
    localparam int NC  = (CW + G - 1) / G;
    localparam int NS  = (SW + 1 + G - 1) / G;
    localparam int NN  = (DMW + G - 1) / G;
    localparam int NA1 = (AW1 + G - 1) / G;

    localparam int LB  = ND*ND + 2;
    localparam int LC  = (NM*NM > NDW*NM ? NM*NM : NDW*NM) + 2;
    localparam int LD0 = (NC*ND > NS*NDW ? NC*ND : NS*NDW);
    localparam int LD  = (LD0 > NN*NN ? LD0 : NN*NN) + 2;
    localparam int LE  = NA1*ND + 2;
    localparam int TE  = LB + LC + LD + LE + 5;
    localparam int VLD_N = TE + P + 1;

    logic en;

    logic signed [P-1:0] p1_in [3];
    logic signed [P-1:0] p2_in [3];
    logic signed [D-1:0] u1_in [3];
    logic signed [D-1:0] u2_in [3];

    logic signed [DW-1:0]    d_reg  [3];
    logic signed [DW-1:0]    ps_reg [3];
    logic signed [D-1:0]     u1_reg [3];
    logic signed [D-1:0]     u2_reg [3];
    logic signed [2*D-1:0]   mb_a   [3];
    logic signed [2*D-1:0]   mb_b   [3];
    logic signed [MW-1:0]    m_reg  [3];
    logic signed [DW-1:0]    d_c    [3];
    logic signed [DW-1:0]    ps_c   [3];
    logic signed [D-1:0]     u1_c   [3];
    logic signed [D-1:0]     u2_c   [3];
    logic signed [2*MW-1:0]  s_p    [3];
    logic signed [DW+MW-1:0] cc_a   [3];
    logic signed [DW+MW-1:0] cc_b   [3];
    logic signed [DW+MW-1:0] dmp    [3];
    logic [SW-1:0]           s_reg;
    logic signed [SW:0]      s_sx;
    logic signed [CW-1:0]    c_reg  [3];
    logic signed [DMW-1:0]   dm_reg;
    logic signed [CW+D-1:0]  a1p    [3];
    logic signed [CW+D-1:0]  a2p    [3];
    logic signed [SPW-1:0]   spp    [3];
    logic signed [N2W-1:0]   n2p;
    logic signed [AW1-1:0]   a1_reg;
    logic signed [AW1-1:0]   a2_reg;
    logic signed [D-1:0]     u1_d   [3];
    logic signed [D-1:0]     u2_d   [3];
    logic signed [AW1+D-1:0] ap1    [3];
    logic signed [AW1+D-1:0] ap2    [3];
    logic signed [SPW-1:0]   sp_e   [3];
    logic signed [NMW-1:0]   num_reg [3];
    logic [N2W-1:0]          n2_e;
    logic [SW-1:0]           s_e;
    logic                    par_c;
    logic                    par_o;
    logic [P-1:0]            mid_o  [3];
    logic [P-1:0]            half_o;

    logic                    vld_reg [VLD_N];
    logic                    res_valid_reg;
    logic [P-1:0]            mid_reg [3];
    logic [P-1:0]            half_reg;
    logic                    par_reg;

    assign en         = !res_valid_reg || !res_stall;
    assign pair_stall = !en;

    assign p1_in = '{p1_x, p1_y, p1_z};
    assign p2_in = '{p2_x, p2_y, p2_z};
    assign u1_in = '{u1_x, u1_y, u1_z};
    assign u2_in = '{u2_x, u2_y, u2_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]  <= DW'(p2_in[i]) - DW'(p1_in[i]);
                ps_reg[i] <= DW'(p2_in[i]) + DW'(p1_in[i]);
                u1_reg[i] <= u1_in[i];
                u2_reg[i] <= u2_in[i];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_vec
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        trcp_mul #(.AW(D), .BW(D), .LAT(LB)) u_mb_a
            (.clk(clk), .en(en), .a(u2_reg[J]), .b(u1_reg[K]), .p(mb_a[i]));
        trcp_mul #(.AW(D), .BW(D), .LAT(LB)) u_mb_b
            (.clk(clk), .en(en), .a(u2_reg[K]), .b(u1_reg[J]), .p(mb_b[i]));

        trcp_delay #(.W(DW), .N(LB + 1)) u_dly_d
            (.clk(clk), .en(en), .din(d_reg[i]), .dout(d_c[i]));
        trcp_delay #(.W(DW), .N(LB + LC + 2)) u_dly_ps
            (.clk(clk), .en(en), .din(ps_reg[i]), .dout(ps_c[i]));
        trcp_delay #(.W(D), .N(LB + LC + 2)) u_dly_u1
            (.clk(clk), .en(en), .din(u1_reg[i]), .dout(u1_c[i]));
        trcp_delay #(.W(D), .N(LB + LC + 2)) u_dly_u2
            (.clk(clk), .en(en), .din(u2_reg[i]), .dout(u2_c[i]));

        trcp_mul #(.AW(MW), .BW(MW), .LAT(LC)) u_ms
            (.clk(clk), .en(en), .a(m_reg[i]), .b(m_reg[i]), .p(s_p[i]));
        trcp_mul #(.AW(DW), .BW(MW), .LAT(LC)) u_mc_a
            (.clk(clk), .en(en), .a(d_c[J]), .b(m_reg[K]), .p(cc_a[i]));
        trcp_mul #(.AW(DW), .BW(MW), .LAT(LC)) u_mc_b
            (.clk(clk), .en(en), .a(d_c[K]), .b(m_reg[J]), .p(cc_b[i]));
        trcp_mul #(.AW(DW), .BW(MW), .LAT(LC)) u_mdm
            (.clk(clk), .en(en), .a(d_c[i]), .b(m_reg[i]), .p(dmp[i]));

        trcp_mul #(.AW(CW), .BW(D), .LAT(LD)) u_ma1
            (.clk(clk), .en(en), .a(c_reg[i]), .b(u2_c[i]), .p(a1p[i]));
        trcp_mul #(.AW(CW), .BW(D), .LAT(LD)) u_ma2
            (.clk(clk), .en(en), .a(c_reg[i]), .b(u1_c[i]), .p(a2p[i]));
        trcp_mul #(.AW(SW + 1), .BW(DW), .LAT(LD)) u_msp
            (.clk(clk), .en(en), .a(s_sx), .b(ps_c[i]), .p(spp[i]));

        trcp_delay #(.W(D), .N(LD + 1)) u_dly_u1d
            (.clk(clk), .en(en), .din(u1_c[i]), .dout(u1_d[i]));
        trcp_delay #(.W(D), .N(LD + 1)) u_dly_u2d
            (.clk(clk), .en(en), .din(u2_c[i]), .dout(u2_d[i]));
        trcp_delay #(.W(SPW), .N(LE + 1)) u_dly_sp
            (.clk(clk), .en(en), .din(spp[i]), .dout(sp_e[i]));

        trcp_mul #(.AW(AW1), .BW(D), .LAT(LE)) u_mp1
            (.clk(clk), .en(en), .a(a1_reg), .b(u1_d[i]), .p(ap1[i]));
        trcp_mul #(.AW(AW1), .BW(D), .LAT(LE)) u_mp2
            (.clk(clk), .en(en), .a(a2_reg), .b(u2_d[i]), .p(ap2[i]));

        trcp_mid #(.POS_W(P), .NUMW(NMW), .SW(SW)) u_mid
            (.clk(clk), .en(en), .num(num_reg[i]), .s(s_e), .mid(mid_o[i]));
    end

    assign s_sx  = {1'b0, s_reg};
    assign par_c = (s_reg == '0);

    trcp_mul #(.AW(DMW), .BW(DMW), .LAT(LD)) u_mn2
        (.clk(clk), .en(en), .a(dm_reg), .b(dm_reg), .p(n2p));
    trcp_delay #(.W(N2W), .N(LE + 2)) u_dly_n2
        (.clk(clk), .en(en), .din(n2p), .dout(n2_e));
    trcp_delay #(.W(SW), .N(LD + LE + 2)) u_dly_s
        (.clk(clk), .en(en), .din(s_reg), .dout(s_e));
    trcp_delay #(.W(1), .N(LD + LE + P + 3)) u_dly_par
        (.clk(clk), .en(en), .din(par_c), .dout(par_o));

    trcp_half #(.POS_W(P), .N2W(N2W), .SW(SW)) u_half
        (.clk(clk), .en(en), .n2(n2_e), .s(s_e), .h(half_o));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i]   <= MW'(mb_a[i]) - MW'(mb_b[i]);
                c_reg[i]   <= CW'(cc_a[i]) - CW'(cc_b[i]);
                num_reg[i] <= NMW'(sp_e[i]) + NMW'(ap1[i]) + NMW'(ap2[i]);
                mid_reg[i] <= par_o ? '0 : mid_o[i];
            end
            s_reg    <= SW'(s_p[0]) + SW'(s_p[1]) + SW'(s_p[2]);
            dm_reg   <= DMW'(dmp[0]) + DMW'(dmp[1]) + DMW'(dmp[2]);
            a1_reg   <= AW1'(a1p[0]) + AW1'(a1p[1]) + AW1'(a1p[2]);
            a2_reg   <= AW1'(a2p[0]) + AW1'(a2p[1]) + AW1'(a2p[2]);
            half_reg <= par_o ? '0 : half_o;
            par_reg  <= par_o;
        end
    end

    // advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VLD_N; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pair_valid;
            for (int i = 1; i < VLD_N; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            res_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    assign res_valid     = res_valid_reg;
    assign mid_x         = mid_reg[0];
    assign mid_y         = mid_reg[1];
    assign mid_z         = mid_reg[2];
    assign half_distance = half_reg;
    assign parallel      = par_reg;

`ifndef NO_ASSERTIONS
    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && parallel |-> mid_x == '0 && mid_y == '0 && mid_z == '0
            && half_distance == '0)
        else $error("parallel result carries nonzero fields");

    a_rise_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(vld_reg[VLD_N-1]))
        else $error("result valid without a valid pipeline tail");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_stall |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");
`endif

endmodule

`default_nettype wire
